// ----- rtl/core/rro_pkg.sv -----
// Shared types and constants for the ring replacement order queue.
// Used by the cell row, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rro_pkg;

   localparam int VALUE_W = 31;
   localparam int POS_W   = 6;
   localparam int LEN_W   = 7;
   localparam int OP_W    = 2;
   localparam int SLOT_W  = 10;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'(64);

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE       = 2'd0,
      OP_MOVE_TO_BACK  = 2'd1,
      OP_MOVE_TO_FRONT = 2'd2
   } op_type;

   typedef logic [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic              load_en;
      logic              shift_en;
      logic              wrap;
      logic [SLOT_W-1:0] head;
      logic [SLOT_W-1:0] target;
      logic [SLOT_W-1:0] last;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/core/rro_cell.sv -----
// One ring slot: holds an entry and takes its left neighbour's entry on a shift.
// Depends on rro_pkg for the command struct and value type.
`timescale 1ns / 1ps
`default_nettype none

module rro_cell #(
   parameter int IDX = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rro_pkg::cmd_type   cmd,
   input  wire rro_pkg::value_type load_value,
   input  wire rro_pkg::value_type saved_value,
   input  wire rro_pkg::value_type prev_value,
   output      rro_pkg::value_type value_q
);

   localparam logic [rro_pkg::SLOT_W-1:0] MY_SLOT = rro_pkg::SLOT_W'(IDX);

   rro_pkg::value_type value_ff;
   rro_pkg::value_type value_in;
   logic               is_head;
   logic               in_use;
   logic               above_head;
   logic               upto_target;
   logic               in_span;

   always_comb begin
      is_head     = (MY_SLOT == cmd.head);
      in_use      = (MY_SLOT <= cmd.last);
      above_head  = (MY_SLOT > cmd.head);
      upto_target = (MY_SLOT <= cmd.target);
      in_span     = in_use & (cmd.wrap ? (above_head | upto_target)
                                       : (above_head & upto_target));
      value_in = value_ff;
      if (cmd.load_en && is_head) begin
         value_in = load_value;
      end else if (cmd.shift_en && is_head) begin
         value_in = saved_value;
      end else if (cmd.shift_en && in_span) begin
         value_in = prev_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value_q = value_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ring_replacement_order_queue.sv -----
// Top level of the ring replacement order queue: head pointer, cell row, result register.
// Depends on rro_pkg and rro_cell.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a ring of page numbers in a row of cells, one cell per slot, with a head
// pointer on the oldest entry. Enqueue (tuser 0) returns the head entry, stores the
// new value there and advances the head; move-to-back (1) and move-to-front (2) lift
// the entry at the given slot if in range, shift the entries from the head up to it
// on by one slot across the whole row, and place it at the head slot, with
// move-to-back then advancing the head. The ring is zero after reset and the length
// register resets to 64. One item is taken per cycle; its result leaves from a
// register in the cycle after acceptance, and the input stalls only while that
// result waits. The length register may be written only while no item is in flight.
module ring_replacement_order_queue #(
   parameter int RING_DEPTH = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // fields: new_value [30:0], position [36:31], zero fill [39:37]
   input  wire logic [rro_pkg::REQ_DATA_W-1:0]     req_tdata,
   // fields: op [1:0]
   input  wire logic [rro_pkg::OP_W-1:0]           req_tuser,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // fields: evicted_value [30:0], head_after [36:31], zero fill [39:37]
   output      logic [rro_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [rro_pkg::LEN_W-1:0]          csr_ring_length,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready
);

   localparam int HW   = $clog2(RING_DEPTH);
   localparam int CMPW = (HW + 1 > rro_pkg::LEN_W) ? HW + 1 : rro_pkg::LEN_W;
   localparam logic [CMPW-1:0] DEPTH_W = CMPW'(RING_DEPTH);

   function automatic logic [CMPW-1:0] clamp_len(input logic [rro_pkg::LEN_W-1:0] v);
      logic [CMPW-1:0] w;
      w = CMPW'(v);
      if (w == '0) begin
         w = CMPW'(1);
      end else if (w > DEPTH_W) begin
         w = DEPTH_W;
      end
      return w;
   endfunction

   logic [rro_pkg::LEN_W-1:0]  ring_length_ff;
   logic [HW-1:0]              head_ff;
   logic [HW-1:0]              head_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [rro_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [rro_pkg::RSP_DATA_W-1:0] rsp_data_in;

   rro_pkg::value_type         cell_value [RING_DEPTH];
   rro_pkg::value_type         new_value;
   rro_pkg::value_type         saved_value;
   rro_pkg::value_type         evicted_value;
   rro_pkg::cmd_type           cmd;
   rro_pkg::op_type            op;
   logic [rro_pkg::POS_W-1:0]  position;
   logic [CMPW-1:0]            eff_len;
   logic [CMPW-1:0]            csr_len;
   logic [HW-1:0]              target_hw;
   logic [HW-1:0]              last_hw;
   logic [HW-1:0]              sel_hw;
   logic [HW-1:0]              next_head;
   logic                       accept;
   logic                       pos_ok;
   logic                       is_move;

   assign op        = rro_pkg::op_type'(req_tuser);
   assign new_value = req_tdata[rro_pkg::VALUE_W-1:0];
   assign position  = req_tdata[rro_pkg::VALUE_W +: rro_pkg::POS_W];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      eff_len   = clamp_len(ring_length_ff);
      csr_len   = clamp_len(csr_ring_length);
      last_hw   = HW'(eff_len - CMPW'(1));
      target_hw = HW'(position);
      pos_ok    = CMPW'(position) < eff_len;
      is_move   = (op == rro_pkg::OP_MOVE_TO_BACK) || (op == rro_pkg::OP_MOVE_TO_FRONT);
      next_head = (CMPW'(head_ff) + CMPW'(1) < eff_len) ? head_ff + HW'(1) : '0;
      sel_hw    = (op == rro_pkg::OP_ENQUEUE) ? head_ff : target_hw;
      saved_value = cell_value[sel_hw];

      cmd.load_en  = accept && (op == rro_pkg::OP_ENQUEUE);
      cmd.shift_en = accept && is_move && pos_ok;
      cmd.wrap     = target_hw < head_ff;
      cmd.head     = rro_pkg::SLOT_W'(head_ff);
      cmd.target   = rro_pkg::SLOT_W'(target_hw);
      cmd.last     = rro_pkg::SLOT_W'(last_hw);
   end

   for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
      rro_pkg::value_type prev_value;
      if (i == 0) begin : g_first
         assign prev_value = cell_value[last_hw];
      end else begin : g_rest
         assign prev_value = cell_value[i-1];
      end
      rro_cell #(
         .IDX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .load_value  (new_value),
         .saved_value (saved_value),
         .prev_value  (prev_value),
         .value_q     (cell_value[i])
      );
   end

   always_comb begin
      head_in = head_ff;
      if (csr_valid && csr_ready) begin
         if (CMPW'(head_ff) >= csr_len) begin
            head_in = '0;
         end
      end else if (accept) begin
         if (op == rro_pkg::OP_ENQUEUE) begin
            head_in = next_head;
         end else if (op == rro_pkg::OP_MOVE_TO_BACK && pos_ok) begin
            head_in = next_head;
         end
      end
   end

   always_comb begin
      evicted_value = (op == rro_pkg::OP_ENQUEUE) ? saved_value : '0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rro_pkg::RSP_DATA_W'({rro_pkg::POS_W'(head_in), evicted_value});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_length_ff <= rro_pkg::RESET_LEN;
         head_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            ring_length_ff <= csr_ring_length;
         end
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rro_checker.sv -----
// Port-level checks on the ring replacement order queue, bound to the top level.
// Depends on rro_pkg and ring_replacement_order_queue.
`timescale 1ns / 1ps
`default_nettype none

module rro_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic [rro_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic [rro_pkg::OP_W-1:0]       req_tuser,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [rro_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready
);

   logic req_fire;
   logic nonenq;

   assign req_fire = req_tvalid && req_tready;
   assign nonenq   = req_tuser != rro_pkg::OP_ENQUEUE;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_item_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted item gave no result");

   a_move_no_evict: assert property (@(posedge clock) disable iff (reset)
      req_fire && nonenq |=> rsp_tdata[rro_pkg::VALUE_W-1:0] == '0)
      else $error("non-enqueue item evicted an entry");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item taken while result stalled");

endmodule

bind ring_replacement_order_queue rro_checker u_rro_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
